### src/gpe_pkg.sv
// Shared types and constants of the glyph row pixel expander.
// No dependencies; imported by every module of the block.
package gpe_pkg;

    localparam int COLOR_BITS      = 16;
    localparam int MAX_LINE_PIXELS = 64;

    localparam int LINE_W    = 6;
    localparam int ROW_W     = 16;
    localparam int FLAG_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 5;

    // Raw line length before clipping: (15 + 15) columns, x2 wide, x2 doubled.
    localparam int RUN_W = 7;
    localparam int COL_W = 6;

    localparam int IN_FIELD_W = LINE_W + ROW_W + 2 * COLOR_BITS;
    localparam int S_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((COLOR_BITS + 7) / 8) * 8;

    typedef logic [COLOR_BITS-1:0] color_t;

    localparam color_t COLOR_RED   = COLOR_BITS'(32'h0000_F800);
    localparam color_t COLOR_BLACK = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GLYPH_WIDTH    = 3'd0,
        REG_GLYPH_HEIGHT   = 3'd1,
        REG_DATA_ROW_COUNT = 3'd2,
        REG_COL_GAP        = 3'd3,
        REG_ROW_GAP        = 3'd4,
        REG_DOUBLE_WIDE    = 3'd5,
        REG_DOUBLE_TALL    = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [3:0] glyph_width;
        logic [4:0] glyph_height;
        logic [4:0] data_row_count;
        logic [3:0] col_gap;
        logic [3:0] row_gap;
        logic       double_wide;
        logic       double_tall;
    } cfg_t;

    typedef struct packed {
        logic [RUN_W-1:0] pixel_count;
        logic [RUN_W-1:0] left_len;
        logic [RUN_W-1:0] ink_len;
        logic [ROW_W-1:0] pattern;
        logic             wide;
        logic             bold;
        logic             plain;
        logic             dup;
        color_t           ink_color;
        color_t           paper_color;
    } line_desc_t;

endpackage

### src/glyph_row_pixel_expander.sv
// Glyph row pixel expander: text-mode character generator back end.
// Input item: one line of a character cell on s_*; result: pixels on m_*, cfg_* port.
//
// Usage:
//   s_tdata carries line number, glyph row bits and colors; s_tuser carries the
//   wide, bold, underline and cursor flags. Each accepted item produces the
//   line's RGB565 pixels on m_tdata, one item per pixel, left to right, with
//   m_tlast on the final pixel. Lines outside the cell or of zero length
//   produce nothing. Lines longer than 64 pixels are cut to 64.
//   After acceptance a line is held in the line register, and each of its pixels
//   passes through the output register. The pixel counter emits one pixel per
//   cycle while m_tready does not stall it, and the next line is accepted in the
//   cycle its predecessor's final pixel enters the output register, so lines
//   stream back to back with no gap.
//   A stall on m_tready holds the output register and the pixel counter; the
//   input side waits until the current line's final pixel enters the output register.
//   Reset (aresetn low, synchronous) drops any line in flight and restores the
//   default registers: 8 columns, 16 rows, 16 data rows, no gaps, no doubling.
//   User writes registers via cfg_we/cfg_index/cfg_wdata only while idle; unchecked.
module glyph_row_pixel_expander import gpe_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // line_number[5:0], glyph_row[21:6], fg_color[37:22], bg_color[53:38], zero pad
    input  logic [S_DATA_W-1:0]  s_tdata,
    // wide_glyph[0], bold_on[1], underline_on[2], cursor_on[3]
    input  logic [FLAG_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pixel_color[15:0]
    output logic [M_DATA_W-1:0]  m_tdata,
    output logic                 m_tlast
);

    localparam int ROW_LO = LINE_W;
    localparam int FG_LO  = ROW_LO + ROW_W;
    localparam int BG_LO  = FG_LO + COLOR_BITS;

    cfg_t       cfg;
    line_desc_t desc;
    color_t     px_color;

    gpe_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    gpe_line_setup u_line_setup (
        .cfg          (cfg),
        .line_number  (s_tdata[LINE_W-1:0]),
        .glyph_row    (s_tdata[FG_LO-1:ROW_LO]),
        .wide_glyph   (s_tuser[0]),
        .bold_on      (s_tuser[1]),
        .underline_on (s_tuser[2]),
        .cursor_on    (s_tuser[3]),
        .fg_color     (s_tdata[BG_LO-1:FG_LO]),
        .bg_color     (s_tdata[BG_LO+COLOR_BITS-1:BG_LO]),
        .desc         (desc)
    );

    gpe_pixel_gen u_pixel_gen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_valid (s_tvalid),
        .line_desc  (desc),
        .line_ready (s_tready),
        .px_valid   (m_tvalid),
        .px_ready   (m_tready),
        .px_color   (px_color),
        .px_last    (m_tlast)
    );

    assign m_tdata = M_DATA_W'(px_color);

endmodule

### src/gpe_cfg_regs.sv
// Configuration register bank of the glyph row pixel expander.
// Depends on gpe_pkg for the register layout and index codes.
module gpe_cfg_regs import gpe_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.glyph_width    <= 4'd8;
            cfg_reg.glyph_height   <= 5'd16;
            cfg_reg.data_row_count <= 5'd16;
            cfg_reg.col_gap        <= 4'd0;
            cfg_reg.row_gap        <= 4'd0;
            cfg_reg.double_wide    <= 1'b0;
            cfg_reg.double_tall    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GLYPH_WIDTH:    cfg_reg.glyph_width    <= cfg_wdata[3:0];
                REG_GLYPH_HEIGHT:   cfg_reg.glyph_height   <= cfg_wdata[4:0];
                REG_DATA_ROW_COUNT: cfg_reg.data_row_count <= cfg_wdata[4:0];
                REG_COL_GAP:        cfg_reg.col_gap        <= cfg_wdata[3:0];
                REG_ROW_GAP:        cfg_reg.row_gap        <= cfg_wdata[3:0];
                REG_DOUBLE_WIDE:    cfg_reg.double_wide    <= cfg_wdata[0];
                REG_DOUBLE_TALL:    cfg_reg.double_tall    <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/gpe_line_setup.sv
// Per-line setup: turns one input item and the configuration into a line descriptor
// (pixel count, margin and ink spans, pattern, colors). Depends on gpe_pkg.
module gpe_line_setup import gpe_pkg::*; (
    input  cfg_t              cfg,
    input  logic [LINE_W-1:0] line_number,
    input  logic [ROW_W-1:0]  glyph_row,
    input  logic              wide_glyph,
    input  logic              bold_on,
    input  logic              underline_on,
    input  logic              cursor_on,
    input  color_t            fg_color,
    input  color_t            bg_color,
    output line_desc_t        desc
);

    logic             dbl_mode;
    logic [2:0]       top_gap;
    logic [2:0]       left_gap;
    logic [4:0]       half_h;
    logic [6:0]       line7;
    logic [ROW_W-1:0] narrow_row;

    logic [4:0]       ink_rows;
    logic             plain_ink;
    logic             plain_in_cell;
    logic [5:0]       idx;
    logic             plain_cur;
    logic             plain_ul;
    logic             plain_forced;
    color_t           forced_color;
    logic [ROW_W-1:0] plain_pat;

    logic [5:0]       ink_lines;
    logic             dbl_in_cell;
    logic             dbl_ink;
    logic [5:0]       rel;
    logic [5:0]       i2;
    logic [6:0]       dbl_i;
    logic             cz;
    logic             dbl_red;
    logic [ROW_W-1:0] dbl_pat;

    logic [4:0]       cols;
    logic [5:0]       units;
    logic [5:0]       ink_cols;
    logic [RUN_W-1:0] total;
    logic [RUN_W-1:0] lm;
    logic [RUN_W-1:0] ik;
    logic             in_cell;

    always_comb begin
        dbl_mode   = cfg.double_wide | cfg.double_tall;
        top_gap    = cfg.row_gap[3:1];
        left_gap   = cfg.col_gap[3:1];
        half_h     = {1'b0, cfg.glyph_height[4:1]};
        line7      = {1'b0, line_number};
        narrow_row = {glyph_row[15:8], 8'h00};

        ink_rows = wide_glyph ? cfg.glyph_height :
                   ((cfg.data_row_count < cfg.glyph_height) ? cfg.data_row_count
                                                            : cfg.glyph_height);
        plain_ink     = (line7 >= 7'(top_gap)) && (line7 < 7'(top_gap) + 7'(ink_rows));
        plain_in_cell = line7 < 7'(cfg.glyph_height) + 7'(cfg.row_gap);
        idx           = plain_ink ? line_number - 6'(top_gap) : line_number;
        plain_cur     = cursor_on && (idx >= {1'b0, half_h});
        plain_ul      = underline_on && (7'(idx) + 7'd1 >= 7'(cfg.glyph_height));
        plain_forced  = plain_cur | plain_ul;
        forced_color  = plain_cur ? COLOR_RED : fg_color;
        plain_pat     = wide_glyph ? ((idx < {1'b0, cfg.data_row_count}) ? glyph_row : '0)
                                   : narrow_row;

        ink_lines   = cfg.double_tall ? {cfg.glyph_height, 1'b0} : {1'b0, cfg.glyph_height};
        dbl_in_cell = line7 < 7'(ink_lines) + 7'(cfg.row_gap);
        dbl_ink     = (line7 >= 7'(top_gap)) && (line7 < 7'(top_gap) + 7'(ink_lines));
        rel         = line_number - 6'(top_gap);
        i2          = cfg.double_tall ? {1'b0, rel[5:1]} : rel;
        dbl_i       = 7'(top_gap) + 7'(i2);
        cz          = cursor_on && (dbl_i >= 7'(half_h));
        dbl_red     = dbl_ink ? cz : cursor_on;
        dbl_pat     = (i2 < {1'b0, cfg.data_row_count})
                    ? (wide_glyph ? glyph_row : narrow_row) : '0;

        cols     = {1'b0, cfg.glyph_width} + {1'b0, cfg.col_gap};
        units    = wide_glyph ? {cols, 1'b0} : {1'b0, cols};
        ink_cols = wide_glyph ? 6'({cfg.glyph_width, 1'b0}) : 6'(cfg.glyph_width);

        if (dbl_mode) begin
            total   = cfg.double_wide ? {units, 1'b0} : 7'(units);
            lm      = dbl_ink ? (cfg.double_wide ? 7'({left_gap, 1'b0}) : 7'(left_gap)) : '0;
            ik      = dbl_ink ? (cfg.double_wide ? {ink_cols, 1'b0} : 7'(ink_cols)) : '0;
            in_cell = dbl_in_cell;
            desc.pattern     = dbl_pat;
            desc.ink_color   = dbl_red ? COLOR_BLACK : fg_color;
            desc.paper_color = dbl_red ? COLOR_RED : bg_color;
        end else begin
            total   = 7'(units);
            lm      = plain_ink ? 7'(left_gap) : '0;
            ik      = plain_ink ? 7'(ink_cols) : '0;
            in_cell = plain_in_cell;
            desc.pattern     = plain_pat;
            desc.ink_color   = plain_forced ? COLOR_BLACK : fg_color;
            desc.paper_color = plain_forced ? forced_color : bg_color;
        end

        if (!in_cell) begin
            desc.pixel_count = '0;
        end else if (total > RUN_W'(MAX_LINE_PIXELS)) begin
            desc.pixel_count = RUN_W'(MAX_LINE_PIXELS);
        end else begin
            desc.pixel_count = total;
        end
        desc.left_len = lm;
        desc.ink_len  = ik;
        desc.wide     = wide_glyph;
        desc.bold     = bold_on;
        desc.plain    = !dbl_mode;
        desc.dup      = cfg.double_wide;
    end

endmodule

### src/gpe_pixel_gen.sv
// Line register, pixel counter and output register: emits one pixel per cycle while px_ready does not stall it.
// Depends on gpe_pkg for the line descriptor and colors.
module gpe_pixel_gen import gpe_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          line_valid,
    input  line_desc_t    line_desc,
    output logic          line_ready,
    output logic          px_valid,
    input  logic          px_ready,
    output color_t        px_color,
    output logic          px_last
);

    logic             busy_reg;
    logic             busy_next;
    logic [RUN_W-1:0] pos_reg;
    logic [RUN_W-1:0] pos_next;
    line_desc_t       desc_reg;
    logic             out_valid_reg;
    color_t           out_color_reg;
    logic             out_last_reg;

    logic             out_free;
    logic             emit;
    logic             last_px;
    logic             line_take;
    logic [RUN_W-1:0] q;
    logic             in_ink;
    logic [COL_W-1:0] col;
    logic             sub;
    logic             cur_bit;
    logic             prev_bit;
    logic             col_in;
    logic             ink_hit;
    color_t           color;

    function automatic logic col_bit(input logic [ROW_W-1:0] pat, input logic wide,
                                     input logic [COL_W-1:0] k);
        logic in_range;
        in_range = wide ? (k < COL_W'(16)) : (k < COL_W'(8));
        return in_range & pat[~k[3:0]];
    endfunction

    always_comb begin
        out_free  = !out_valid_reg || px_ready;
        emit      = busy_reg && out_free;
        last_px   = pos_reg == desc_reg.pixel_count - RUN_W'(1);
        line_ready = !busy_reg || (emit && last_px);
        line_take = line_valid && line_ready && (line_desc.pixel_count != '0);

        q        = pos_reg - desc_reg.left_len;
        in_ink   = (pos_reg >= desc_reg.left_len) &&
                   (pos_reg < desc_reg.left_len + desc_reg.ink_len);
        col      = desc_reg.dup ? q[RUN_W-1:1] : q[COL_W-1:0];
        sub      = desc_reg.dup & q[0];
        cur_bit  = col_bit(desc_reg.pattern, desc_reg.wide, col);
        prev_bit = (col != '0) && col_bit(desc_reg.pattern, desc_reg.wide, col - COL_W'(1));
        col_in   = desc_reg.wide ? (col < COL_W'(16)) : (col < COL_W'(8));
        if (desc_reg.plain) begin
            ink_hit = cur_bit | (desc_reg.bold & prev_bit & col_in);
        end else begin
            ink_hit = sub ? cur_bit : (cur_bit | (desc_reg.bold & prev_bit));
        end
        color = (in_ink && ink_hit) ? desc_reg.ink_color : desc_reg.paper_color;

        if (line_take) begin
            busy_next = 1'b1;
            pos_next  = '0;
        end else if (emit) begin
            busy_next = !last_px;
            pos_next  = pos_reg + RUN_W'(1);
        end else begin
            busy_next = busy_reg;
            pos_next  = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (px_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (line_take) begin
            desc_reg <= line_desc;
        end
        if (emit) begin
            out_color_reg <= color;
            out_last_reg  <= last_px;
        end
    end

    assign px_valid = out_valid_reg;
    assign px_color = out_color_reg;
    assign px_last  = out_last_reg;

`ifndef SYNTHESIS
    a_pos_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pos_reg < desc_reg.pixel_count))
        else $error("pixel position beyond line length");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (desc_reg.pixel_count != '0 &&
                      desc_reg.pixel_count <= RUN_W'(MAX_LINE_PIXELS)))
        else $error("active line has bad pixel count");

    a_last_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last_px) |=> (out_valid_reg && out_last_reg))
        else $error("final pixel not marked last");

    a_pos_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !last_px) |=> (busy_reg && pos_reg == $past(pos_reg) + RUN_W'(1)))
        else $error("pixel position skipped");
`endif

endmodule

### tb/sv/glyph_row_pixel_expander_test.sv
// Self-checking testbench for glyph_row_pixel_expander: streams character-cell lines
// through a set of register modes and checks every pixel against a local line expander.
// Depends on gpe_pkg and the glyph_row_pixel_expander RTL.
`timescale 1ns / 1ps

module glyph_row_pixel_expander_test;
    import gpe_pkg::*;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [ROW_W-1:0]  row;
        logic              wide;
        logic              bold;
        logic              underline;
        logic              cursor;
        color_t            fg;
        color_t            bg;
    } line_item_t;

    typedef struct packed {
        color_t color;
        logic   last;
    } pixel_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_GLYPH_WIDTH;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic [FLAG_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;

    glyph_row_pixel_expander u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    int mode_gw = 8;
    int mode_gh = 16;
    int mode_dr = 16;
    int mode_cg = 0;
    int mode_rg = 0;
    int mode_dw = 0;
    int mode_dt = 0;

    line_item_t pending_lines[$];
    pixel_t     expected_pixels[$];
    color_t     line_px[$];

    line_item_t offered_line;
    bit         line_offered = 0;
    bit         idle_on = 1;
    bit         long_stall_go = 0;
    bit         long_stall_taken = 0;
    int         send_gap = 0;
    int         rx_wait = 0;
    int         mismatch_count = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("glyph_row_pixel_expander test failed");
        $finish;
    end

    function automatic void emit(color_t c, int count);
        for (int k = 0; k < count; k++) begin
            if (line_px.size() < MAX_LINE_PIXELS) line_px.push_back(c);
        end
    endfunction

    function automatic logic pat_bit(logic [15:0] pat, int nbits, int j);
        if (j >= nbits) return 1'b0;
        return pat[nbits-1-j];
    endfunction

    function automatic void expand_line(line_item_t it);
        int L, crow, urow, st, sl, mult, nbits, inkrows, idx, tate, units, i2, dup;
        bit ink, forced, cz, b, prev;
        color_t fc, base, c1, c2, margin;
        logic [15:0] pat;
        L = it.line;
        crow = mode_gh / 2 - 1;
        urow = mode_gh - 2;
        st = mode_rg / 2;
        sl = mode_cg / 2;
        mult = it.wide ? 2 : 1;
        nbits = it.wide ? 16 : 8;
        line_px.delete();
        if (!mode_dw && !mode_dt) begin
            if (L >= mode_gh + mode_rg) return;
            inkrows = it.wide ? mode_gh : (mode_dr < mode_gh ? mode_dr : mode_gh);
            ink = (L >= st) && (L < st + inkrows);
            idx = ink ? L - st : L;
            forced = 1'b0;
            fc = COLOR_BLACK;
            if (it.cursor && idx > crow) begin
                forced = 1'b1;
                fc = COLOR_RED;
            end else if (it.underline && idx > urow) begin
                forced = 1'b1;
                fc = it.fg;
            end
            base = forced ? fc : it.bg;
            if (!ink) begin
                emit(base, (mode_gw + mode_cg) * mult);
            end else begin
                pat = it.wide ? (idx < mode_dr ? it.row : 16'h0000) : (it.row >> 8);
                if (it.bold) pat = pat | (pat >> 1);
                emit(base, sl);
                for (int j = 0; j < mode_gw * mult; j++) begin
                    b = pat_bit(pat, nbits, j);
                    if (forced) emit(b ? COLOR_BLACK : fc, 1);
                    else emit(b ? it.fg : it.bg, 1);
                end
                emit(base, mode_cg * mult - sl);
            end
        end else begin
            tate = mode_dt ? 2 : 1;
            if (L >= mode_gh * tate + mode_rg) return;
            if (L < st || L >= st + mode_gh * tate) begin
                units = (mode_gw + mode_cg) * mult;
                emit(it.cursor ? COLOR_RED : it.bg, mode_dw ? units * 2 : units);
            end else begin
                i2 = (L - st) / tate;
                cz = it.cursor && (st + i2 > crow);
                pat = (i2 < mode_dr) ? (it.wide ? it.row : (it.row >> 8)) : 16'h0000;
                margin = cz ? COLOR_RED : it.bg;
                dup = mode_dw ? 2 : 1;
                prev = 1'b0;
                emit(margin, sl * dup);
                for (int j = 0; j < mode_gw * mult; j++) begin
                    b = pat_bit(pat, nbits, j);
                    if (cz) begin
                        c2 = b ? COLOR_BLACK : COLOR_RED;
                        c1 = (it.bold && prev) ? COLOR_BLACK : c2;
                    end else begin
                        c2 = b ? it.fg : it.bg;
                        c1 = (it.bold && prev) ? it.fg : c2;
                    end
                    emit(c1, 1);
                    if (mode_dw) emit(c2, 1);
                    prev = b;
                end
                emit(margin, (mode_cg * mult - sl) * dup);
            end
        end
        for (int j = 0; j < line_px.size(); j++)
            expected_pixels.push_back('{color: line_px[j], last: (j == line_px.size() - 1)});
    endfunction

    function automatic int cell_line_count();
        if (!mode_dw && !mode_dt) return mode_gh + mode_rg;
        return mode_gh * (mode_dt ? 2 : 1) + mode_rg;
    endfunction

    function automatic color_t pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return color_t'($urandom);
        endcase
    endfunction

    function automatic line_item_t make_line(int line, logic [15:0] row, bit wide, bit bold,
                                             bit ul, bit cur, color_t fg, color_t bg);
        line_item_t it;
        it.line = LINE_W'(line);
        it.row = row;
        it.wide = wide;
        it.bold = bold;
        it.underline = ul;
        it.cursor = cur;
        it.fg = fg;
        it.bg = bg;
        return it;
    endfunction

    function automatic line_item_t random_line();
        int line;
        if ($urandom_range(0, 9) == 0) line = $urandom_range(0, 47);
        else line = $urandom_range(0, cell_line_count() - 1);
        return make_line(line, pick_word(), $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom_range(0, 1), pick_word(), pick_word());
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
            line_offered = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expand_line(offered_line);
                line_offered = 0;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    s_tvalid <= 1'b0;
                    send_gap--;
                end else if (pending_lines.size() > 0) begin
                    offered_line = pending_lines.pop_front();
                    line_offered = 1;
                    s_tvalid <= 1'b1;
                    s_tdata <= S_DATA_W'({offered_line.bg, offered_line.fg,
                                          offered_line.row, offered_line.line});
                    s_tuser <= {offered_line.cursor, offered_line.underline,
                                offered_line.bold, offered_line.wide};
                    if (idle_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 13);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        pixel_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected pixel, expected none, actual color %h last %b",
                         $time, m_tdata[COLOR_BITS-1:0], m_tlast);
            end else begin
                e = expected_pixels.pop_front();
                if (m_tdata[COLOR_BITS-1:0] !== e.color || m_tlast !== e.last) begin
                    mismatch_count++;
                    $display("%0t: pixel mismatch, expected color %h last %b, %s %h last %b",
                             $time, e.color, e.last, "actual color",
                             m_tdata[COLOR_BITS-1:0], m_tlast);
                end
            end
        end
        if (long_stall_go && !long_stall_taken) begin
            long_stall_taken = 1;
            rx_wait = 300;
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            rx_wait = $urandom_range(0, 12);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_reg(cfg_index_t idx, int value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DAT_W'(value);
    endtask

    task automatic set_mode(int gw, int gh, int dr, int cg, int rg, int dw, int dt);
        write_reg(REG_GLYPH_WIDTH, gw);
        write_reg(REG_GLYPH_HEIGHT, gh);
        write_reg(REG_DATA_ROW_COUNT, dr);
        write_reg(REG_COL_GAP, cg);
        write_reg(REG_ROW_GAP, rg);
        write_reg(REG_DOUBLE_WIDE, dw);
        write_reg(REG_DOUBLE_TALL, dt);
        @(posedge aclk);
        cfg_we <= 1'b0;
        mode_gw = gw & 15;
        mode_gh = gh & 31;
        mode_dr = dr & 31;
        mode_cg = cg & 15;
        mode_rg = rg & 15;
        mode_dw = dw & 1;
        mode_dt = dt & 1;
    endtask

    task automatic wait_drained();
        while (pending_lines.size() != 0 || line_offered || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    initial begin
        int count;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int ph = 0; ph < 14; ph++) begin
            case (ph)
                0: ;
                1: set_mode(1, 1, 1, 0, 0, 0, 0);
                2: set_mode(8, 16, 16, 8, 8, 0, 0);
                3: set_mode(8, 16, 8, 3, 5, 0, 0);
                4: set_mode(8, 16, 16, 8, 8, 1, 1);
                5: set_mode(5, 9, 4, 7, 3, 1, 0);
                6: set_mode(6, 12, 10, 2, 6, 0, 1);
                7: set_mode(12, 16, 16, 13, 2, 1, 0);
                8: set_mode(0, 4, 4, 0, 1, 0, 0);
                default: set_mode($urandom_range(1, 8), $urandom_range(1, 16),
                                  $urandom_range(1, 16), $urandom_range(0, 8),
                                  $urandom_range(0, 8), $urandom_range(0, 1),
                                  $urandom_range(0, 1));
            endcase
            idle_on = (ph == 13) ? 0 : ($urandom_range(0, 3) != 0);
            count = (ph == 8) ? 6 : 31;
            if (ph == 0) begin
                pending_lines.push_back(make_line(0, 16'hFFFF, 0, 0, 0, 0, 16'hFFFF, 16'h0000));
                pending_lines.push_back(make_line(15, 16'h0000, 0, 0, 1, 0, 16'h1234, 16'hFFFF));
                pending_lines.push_back(make_line(14, 16'hF0F0, 0, 0, 1, 0, 16'h1234, 16'h0000));
                pending_lines.push_back(make_line(8, 16'hA500, 0, 0, 0, 1, 16'hFFFF, 16'h5555));
                pending_lines.push_back(make_line(7, 16'hA500, 0, 0, 0, 1, 16'hFFFF, 16'h5555));
                pending_lines.push_back(make_line(3, 16'h8100, 0, 1, 0, 0, 16'hAAAA, 16'h0000));
                pending_lines.push_back(make_line(5, 16'h8001, 1, 1, 0, 0, 16'h0F0F, 16'hF0F0));
                pending_lines.push_back(make_line(15, 16'hFFFF, 1, 0, 1, 1, 16'h07E0, 16'h001F));
                pending_lines.push_back(make_line(16, 16'h5A5A, 0, 0, 0, 0, 16'h1111, 16'h2222));
                pending_lines.push_back(make_line(47, 16'hFFFF, 1, 1, 1, 1, 16'hFFFF, 16'hFFFF));
                pending_lines.push_back(make_line(10, 16'h0001, 1, 0, 0, 0, 16'hFFFF, 16'h0000));
                count = 20;
            end
            if (ph == 4) long_stall_go = 1;
            for (int k = 0; k < count; k++) pending_lines.push_back(random_line());
            wait_drained();
        end
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("glyph_row_pixel_expander test passed");
        else
            $display("glyph_row_pixel_expander test failed");
        $finish;
    end

endmodule
